>>> rtl/core/qxmm_pkg.sv
// ----------------------------------------------------------------------------
// qxmm_pkg
// shared types, constants and the square root step of the x quadrotor mixer
// ----------------------------------------------------------------------------
package qxmm_pkg;

    localparam int MOTOR_COUNT     = 4;
    localparam int AXIS_COUNT      = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int SQRT_STAGES     = 8;
    localparam int STEPS_PER_STAGE = 2;

    // register index codes
    localparam logic [2:0] REG_THRUST_GAIN     = 3'd0;
    localparam logic [2:0] REG_ROLL_PITCH_GAIN = 3'd1;
    localparam logic [2:0] REG_YAW_GAIN        = 3'd2;
    localparam logic [2:0] REG_SPEED_FLOOR     = 3'd3;
    localparam logic [2:0] REG_SPEED_CEILING   = 3'd4;

    localparam logic [15:0] SPEED_CEILING_RESET = 16'hFFFF;

    // bit a set: torque on axis a (x, y, z) adds to that motor
    localparam logic [AXIS_COUNT-1:0] AXIS_PLUS [MOTOR_COUNT] =
        '{3'b110, 3'b000, 3'b101, 3'b011};

    typedef logic [MOTOR_COUNT-1:0][31:0] sq_vec_t;
    typedef logic [MOTOR_COUNT-1:0][15:0] speed_vec_t;

    typedef struct packed {
        logic [31:0] thrust_gain;
        logic [31:0] roll_pitch_gain;
        logic [31:0] yaw_gain;
    } gains_t;

    typedef struct packed {
        logic [15:0] speed_floor;
        logic [15:0] speed_ceiling;
    } limits_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] root;
    } sqrt_lane_t;

    typedef sqrt_lane_t [MOTOR_COUNT-1:0] sqrt_vec_t;

    // one step of the digit-by-digit integer square root
    function automatic sqrt_lane_t sqrt_step(sqrt_lane_t s, logic [3:0] k);
        logic [31:0] b;
        logic [31:0] t;
        sqrt_lane_t  r;
        b = 32'h4000_0000 >> {k, 1'b0};
        t = s.root + b;
        r = s;
        if (s.rem >= t)
        begin
            r.rem  = s.rem - t;
            r.root = (s.root >> 1) + b;
        end
        else
        begin
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/qxmm_front.sv
// ----------------------------------------------------------------------------
// qxmm_front
// accepts commands, forms gain products and the four squared motor speeds
// ----------------------------------------------------------------------------
module qxmm_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            thrust_cmd,
    input  logic signed [15:0]     torque_x,
    input  logic signed [15:0]     torque_y,
    input  logic signed [15:0]     torque_z,
    input  qxmm_pkg::gains_t       gains,
    input  qxmm_pkg::q_stat_t      q_stat,
    output logic                   push,
    output qxmm_pkg::sq_vec_t      push_sq
);

    logic                     f_adv;
    logic                     f1_valid_reg;
    logic                     f2_valid_reg;
    logic [47:0]              base_reg;
    logic [47:0]              base_next;
    logic signed [48:0]       term_reg  [qxmm_pkg::AXIS_COUNT];
    logic signed [48:0]       term_next [qxmm_pkg::AXIS_COUNT];
    qxmm_pkg::sq_vec_t        sq_reg;
    qxmm_pkg::sq_vec_t        sq_next;

    assign f_adv    = !f2_valid_reg || !q_stat.full;
    assign in_stall = !f_adv;
    assign push     = f2_valid_reg && !q_stat.full;
    assign push_sq  = sq_reg;

    // stage one: products
    always_comb
    begin
        base_next    = 48'(thrust_cmd) * 48'(gains.thrust_gain);
        term_next[0] = 49'(torque_x) * 49'($signed({1'b0, gains.roll_pitch_gain}));
        term_next[1] = 49'(torque_y) * 49'($signed({1'b0, gains.roll_pitch_gain}));
        term_next[2] = 49'(torque_z) * 49'($signed({1'b0, gains.yaw_gain}));
    end

    // stage two: signed motor sums, floor at zero, scale and saturate
    always_comb
    begin
        logic signed [53:0] sum;
        sq_next = '0;
        for (int m = 0; m < qxmm_pkg::MOTOR_COUNT; m++)
        begin
            sum = $signed({2'b00, base_reg, 4'b0000});
            for (int a = 0; a < qxmm_pkg::AXIS_COUNT; a++)
            begin
                if (qxmm_pkg::AXIS_PLUS[m][a])
                    sum = sum + 54'(term_reg[a]);
                else
                    sum = sum - 54'(term_reg[a]);
            end
            if (sum <= 0)
                sq_next[m] = '0;
            else if (sum[52])
                sq_next[m] = '1;
            else
                sq_next[m] = sum[51:20];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (f_adv)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            base_reg <= base_next;
            for (int a = 0; a < qxmm_pkg::AXIS_COUNT; a++)
                term_reg[a] <= term_next[a];
            sq_reg <= sq_next;
        end
    end

endmodule

>>> rtl/core/qxmm_queue.sv
// ----------------------------------------------------------------------------
// qxmm_queue
// short fifo of squared speed sets between front and back
// ----------------------------------------------------------------------------
module qxmm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qxmm_pkg::sq_vec_t  push_sq,
    input  logic               pop,
    output qxmm_pkg::sq_vec_t  head_sq,
    output qxmm_pkg::q_stat_t  q_stat
);

    qxmm_pkg::sq_vec_t                 mem_reg [qxmm_pkg::QUEUE_DEPTH];
    logic [qxmm_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [qxmm_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [qxmm_pkg::QUEUE_PTR_W:0]    count_reg;
    logic [qxmm_pkg::QUEUE_PTR_W:0]    count_next;

    assign head_sq      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == (qxmm_pkg::QUEUE_PTR_W + 1)'(qxmm_pkg::QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_sq;
    end

endmodule

>>> rtl/core/qxmm_back.sv
// ----------------------------------------------------------------------------
// qxmm_back
// pipelined square root of four lanes, clamp to limits, output register
// ----------------------------------------------------------------------------
module qxmm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qxmm_pkg::q_stat_t      q_stat,
    input  qxmm_pkg::sq_vec_t      head_sq,
    output logic                   pop,
    input  qxmm_pkg::limits_t      limits,
    output logic                   out_valid,
    input  logic                   out_stall,
    output qxmm_pkg::speed_vec_t   speeds,
    output logic                   clamped_flag
);

    localparam int LAST = qxmm_pkg::SQRT_STAGES - 1;

    logic                                b_adv;
    logic [qxmm_pkg::SQRT_STAGES-1:0]    st_valid_reg;
    qxmm_pkg::sqrt_vec_t                 st_reg   [qxmm_pkg::SQRT_STAGES];
    qxmm_pkg::sqrt_vec_t                 st_in    [qxmm_pkg::SQRT_STAGES];
    qxmm_pkg::sqrt_vec_t                 st_next  [qxmm_pkg::SQRT_STAGES];
    logic                                out_valid_reg;
    qxmm_pkg::speed_vec_t                speeds_reg;
    qxmm_pkg::speed_vec_t                speeds_next;
    logic                                flag_reg;
    logic                                flag_next;

    assign b_adv        = !(out_valid_reg && out_stall);
    assign pop          = b_adv && !q_stat.empty;
    assign out_valid    = out_valid_reg;
    assign speeds       = speeds_reg;
    assign clamped_flag = flag_reg;

    always_comb
    begin
        for (int m = 0; m < qxmm_pkg::MOTOR_COUNT; m++)
        begin
            st_in[0][m].rem  = head_sq[m];
            st_in[0][m].root = '0;
        end
        for (int s = 1; s < qxmm_pkg::SQRT_STAGES; s++)
            st_in[s] = st_reg[s-1];
    end

    always_comb
    begin
        qxmm_pkg::sqrt_lane_t lane;
        for (int s = 0; s < qxmm_pkg::SQRT_STAGES; s++)
        begin
            for (int m = 0; m < qxmm_pkg::MOTOR_COUNT; m++)
            begin
                lane = st_in[s][m];
                for (int k = 0; k < qxmm_pkg::STEPS_PER_STAGE; k++)
                    lane = qxmm_pkg::sqrt_step(lane,
                        4'(s * qxmm_pkg::STEPS_PER_STAGE + k));
                st_next[s][m] = lane;
            end
        end
    end

    // clamp, floor wins over ceiling
    always_comb
    begin
        logic [15:0] w;
        logic        below;
        logic        above;
        flag_next   = 1'b0;
        speeds_next = '0;
        for (int m = 0; m < qxmm_pkg::MOTOR_COUNT; m++)
        begin
            w     = st_reg[LAST][m].root[15:0];
            below = w < limits.speed_floor;
            above = w > limits.speed_ceiling;
            if (below || above)
                flag_next = 1'b1;
            if (below)
                speeds_next[m] = limits.speed_floor;
            else if (above)
                speeds_next[m] = limits.speed_ceiling;
            else
                speeds_next[m] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            st_valid_reg  <= {st_valid_reg[qxmm_pkg::SQRT_STAGES-2:0], !q_stat.empty};
            out_valid_reg <= st_valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            for (int s = 0; s < qxmm_pkg::SQRT_STAGES; s++)
                st_reg[s] <= st_next[s];
            speeds_reg <= speeds_next;
            flag_reg   <= flag_next;
        end
    end

endmodule

>>> rtl/core/quad_x_motor_mixer_top.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_top
// x quadrotor motor mixer: thrust and torques in, four clamped speeds out
// ----------------------------------------------------------------------------
// Takes one command item per cycle while in_stall is low and returns one
// result item per command, in order. From acceptance to output valid an item
// passes two front stages (gain products, then motor sums), the four-entry
// queue, eight square root stages of two root digits each for all four
// motors side by side, and the clamp/output register. The 16-digit
// square root sets the depth. The front keeps taking items while the output
// is stalled until the queue is full. Configuration writes are always taken
// (cfg_ready is high) and must only be made while no item is in flight.
module quad_x_motor_mixer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        thrust_cmd,
    input  logic signed [15:0] torque_x,
    input  logic signed [15:0] torque_y,
    input  logic signed [15:0] torque_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        speed_front_right,
    output logic [15:0]        speed_back_left,
    output logic [15:0]        speed_front_left,
    output logic [15:0]        speed_back_right,
    output logic               clamped_flag,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0]              thrust_gain_reg;
    logic [31:0]              roll_pitch_gain_reg;
    logic [31:0]              yaw_gain_reg;
    logic [15:0]              speed_floor_reg;
    logic [15:0]              speed_ceiling_reg;
    qxmm_pkg::gains_t         gains;
    qxmm_pkg::limits_t        limits;
    qxmm_pkg::q_stat_t        q_stat;
    qxmm_pkg::sq_vec_t        push_sq;
    qxmm_pkg::sq_vec_t        head_sq;
    qxmm_pkg::speed_vec_t     speeds;
    logic                     push;
    logic                     pop;

    assign cfg_ready              = 1'b1;
    assign gains.thrust_gain      = thrust_gain_reg;
    assign gains.roll_pitch_gain  = roll_pitch_gain_reg;
    assign gains.yaw_gain         = yaw_gain_reg;
    assign limits.speed_floor     = speed_floor_reg;
    assign limits.speed_ceiling   = speed_ceiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thrust_gain_reg     <= '0;
            roll_pitch_gain_reg <= '0;
            yaw_gain_reg        <= '0;
            speed_floor_reg     <= '0;
            speed_ceiling_reg   <= qxmm_pkg::SPEED_CEILING_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qxmm_pkg::REG_THRUST_GAIN:     thrust_gain_reg     <= cfg_data;
                qxmm_pkg::REG_ROLL_PITCH_GAIN: roll_pitch_gain_reg <= cfg_data;
                qxmm_pkg::REG_YAW_GAIN:        yaw_gain_reg        <= cfg_data;
                qxmm_pkg::REG_SPEED_FLOOR:     speed_floor_reg     <= cfg_data[15:0];
                qxmm_pkg::REG_SPEED_CEILING:   speed_ceiling_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    qxmm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .thrust_cmd (thrust_cmd),
        .torque_x   (torque_x),
        .torque_y   (torque_y),
        .torque_z   (torque_z),
        .gains      (gains),
        .q_stat     (q_stat),
        .push       (push),
        .push_sq    (push_sq)
    );

    qxmm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_sq (push_sq),
        .pop     (pop),
        .head_sq (head_sq),
        .q_stat  (q_stat)
    );

    qxmm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_sq      (head_sq),
        .pop          (pop),
        .limits       (limits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .speeds       (speeds),
        .clamped_flag (clamped_flag)
    );

    assign speed_front_right = speeds[0];
    assign speed_back_left   = speeds[1];
    assign speed_front_left  = speeds[2];
    assign speed_back_right  = speeds[3];

    // front only holds off while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.full |-> !in_stall)
        else $error("front stalled with queue space free");

    // unflagged speeds lie inside the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !clamped_flag) |->
            (speed_front_right >= speed_floor_reg && speed_front_right <= speed_ceiling_reg
             && speed_back_left >= speed_floor_reg && speed_back_left <= speed_ceiling_reg
             && speed_front_left >= speed_floor_reg && speed_front_left <= speed_ceiling_reg
             && speed_back_right >= speed_floor_reg && speed_back_right <= speed_ceiling_reg))
        else $error("unflagged speed outside limits");

    // crossed limits always clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && speed_floor_reg > speed_ceiling_reg) |-> clamped_flag)
        else $error("crossed limits without clamp flag");

endmodule
